// ===== rtl/fta_pkg.sv =====
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types, operation codes and helpers of the truncating fp32 ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   localparam int EXP_BIAS    = 127;
   localparam int MANT_W      = 24;   // mantissa with implicit one
   localparam int DIV_BITS    = 3;    // quotient bits resolved per stage
   localparam int DIV_STAGES  = MANT_W / DIV_BITS;
   localparam int DIV_LAT     = DIV_STAGES + 1;
   localparam int AM_LAT      = 3;
   localparam int PAD_LAT     = DIV_LAT - AM_LAT;

   typedef struct packed {
      logic        sign;
      logic [7:0]  exponent;
      logic [22:0] mantissa;
      logic        oor;
   } res_type;

   // Wrap an unbounded 10-bit signed exponent into a result.
   function automatic res_type make_res(input logic sign, input logic signed [9:0] e,
                                        input logic [22:0] mant);
      res_type r;
      r.sign     = sign;
      r.exponent = e[7:0];
      r.mantissa = mant;
      r.oor      = e[9] | e[8];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fta_addsub.sv =====
// ----------------------------------------------------------------------------
// fta_addsub
// Three-stage add path: align, signed add, normalize.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_addsub
   import fta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic        a_sign,
   input  wire logic [7:0]  a_exponent,
   input  wire logic [22:0] a_mantissa,
   input  wire logic        b_sign,
   input  wire logic [7:0]  b_exponent,
   input  wire logic [22:0] b_mantissa,
   output res_type          res
);

   logic [7:0]  exp1_ff, exp1_in;
   logic [23:0] big1_ff, big1_in, sml1_ff, sml1_in;
   logic        bs1_ff, bs1_in, ss1_ff, ss1_in;
   logic [7:0]  diff;
   logic [23:0] sml_raw;

   // Align the operand with the smaller exponent
   always_comb begin
      if (a_exponent > b_exponent) begin
         diff    = a_exponent - b_exponent;
         exp1_in = a_exponent;
         big1_in = {1'b1, a_mantissa};
         bs1_in  = a_sign;
         sml_raw = {1'b1, b_mantissa};
         ss1_in  = b_sign;
      end else begin
         diff    = b_exponent - a_exponent;
         exp1_in = b_exponent;
         big1_in = {1'b1, b_mantissa};
         bs1_in  = b_sign;
         sml_raw = {1'b1, a_mantissa};
         ss1_in  = a_sign;
      end
      sml1_in = (diff >= 8'd24) ? '0 : (sml_raw >> diff[4:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exp1_ff <= exp1_in;
         big1_ff <= big1_in;
         sml1_ff <= sml1_in;
         bs1_ff  <= bs1_in;
         ss1_ff  <= ss1_in;
      end
   end

   logic [7:0]  exp2_ff;
   logic [24:0] mag2_ff, mag2_in;
   logic        sg2_ff, sg2_in;

   // Add signed magnitudes
   always_comb begin
      if (bs1_ff == ss1_ff) begin
         mag2_in = {1'b0, big1_ff} + {1'b0, sml1_ff};
         sg2_in  = bs1_ff;
      end else if (big1_ff >= sml1_ff) begin
         mag2_in = {1'b0, big1_ff - sml1_ff};
         sg2_in  = bs1_ff;
      end else begin
         mag2_in = {1'b0, sml1_ff - big1_ff};
         sg2_in  = ss1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exp2_ff <= exp1_ff;
         mag2_ff <= mag2_in;
         sg2_ff  <= sg2_in;
      end
   end

   res_type      res_ff, res_in;
   logic [4:0]   lz;
   logic [23:0]  shifted;
   logic signed [9:0] e;

   // Normalize: on a carry take bits 23:1, else shift the leading one to bit 23
   always_comb begin
      lz = 5'd0;
      e  = '0;
      for (int i = 0; i < 24; i++) begin
         if (mag2_ff[i]) lz = 5'(23 - i);
      end
      shifted = mag2_ff[23:0] << lz;
      if (mag2_ff == '0) begin
         res_in = '0;
      end else if (mag2_ff[24]) begin
         e      = $signed({2'b00, exp2_ff}) + 10'sd1;
         res_in = make_res(sg2_ff, e, mag2_ff[23:1]);
      end else begin
         e      = $signed({2'b00, exp2_ff}) - $signed({5'd0, lz});
         res_in = make_res(sg2_ff, e, shifted[22:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== rtl/fta_mul.sv =====
// ----------------------------------------------------------------------------
// fta_mul
// Three-stage multiply path: product, normalize, pack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_mul
   import fta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic        a_sign,
   input  wire logic [7:0]  a_exponent,
   input  wire logic [22:0] a_mantissa,
   input  wire logic        b_sign,
   input  wire logic [7:0]  b_exponent,
   input  wire logic [22:0] b_mantissa,
   output res_type          res
);

   logic [47:0]       prod_ff;
   logic signed [9:0] exp1_ff, exp2_ff;
   logic              sg1_ff, sg2_ff;
   logic [22:0]       mant2_ff;
   res_type           res_ff;

   // Multiply mantissas, add exponents
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {1'b1, a_mantissa} * {1'b1, b_mantissa};
         exp1_ff <= $signed({2'b00, a_exponent}) + $signed({2'b00, b_exponent})
                    - 10'(EXP_BIAS);
         sg1_ff  <= a_sign ^ b_sign;
      end
   end

   // Truncate the product to 24 bits
   always_ff @(posedge clock) begin
      if (en) begin
         sg2_ff <= sg1_ff;
         if (prod_ff[47]) begin
            mant2_ff <= prod_ff[46:24];
            exp2_ff  <= exp1_ff + 10'sd1;
         end else begin
            mant2_ff <= prod_ff[45:23];
            exp2_ff  <= exp1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= make_res(sg2_ff, exp2_ff, mant2_ff);
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== rtl/fta_div.sv =====
// ----------------------------------------------------------------------------
// fta_div
// Pipelined restoring divider, a few quotient bits per stage, then normalize.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_div
   import fta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic        a_sign,
   input  wire logic [7:0]  a_exponent,
   input  wire logic [22:0] a_mantissa,
   input  wire logic        b_sign,
   input  wire logic [7:0]  b_exponent,
   input  wire logic [22:0] b_mantissa,
   output res_type          res
);

   logic [24:0]       rem_ff  [DIV_STAGES];
   logic [23:0]       quo_ff  [DIV_STAGES];
   logic [23:0]       dvs_ff  [DIV_STAGES];
   logic signed [9:0] exp_ff  [DIV_STAGES];
   logic              sg_ff   [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [24:0]       rem_src;
      logic [23:0]       quo_src, dvs_src;
      logic signed [9:0] exp_src;
      logic              sg_src;
      logic [24:0]       rem_in;
      logic [23:0]       quo_in;

      if (k == 0) begin : g_seed
         assign rem_src = {2'b01, a_mantissa};
         assign quo_src = '0;
         assign dvs_src = {1'b1, b_mantissa};
         assign exp_src = $signed({2'b00, a_exponent}) - $signed({2'b00, b_exponent})
                          + 10'(EXP_BIAS);
         assign sg_src  = a_sign ^ b_sign;
      end else begin : g_chain
         assign rem_src = rem_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign dvs_src = dvs_ff[k-1];
         assign exp_src = exp_ff[k-1];
         assign sg_src  = sg_ff[k-1];
      end

      // Resolve a few quotient bits: compare, subtract, shift
      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         for (int j = 0; j < DIV_BITS; j++) begin
            if (rem_in >= {1'b0, dvs_src}) begin
               rem_in = rem_in - {1'b0, dvs_src};
               quo_in = {quo_in[22:0], 1'b1};
            end else begin
               quo_in = {quo_in[22:0], 1'b0};
            end
            rem_in = {rem_in[23:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            dvs_ff[k] <= dvs_src;
            exp_ff[k] <= exp_src;
            sg_ff[k]  <= sg_src;
         end
      end
   end

   res_type res_ff;
   logic [23:0]       q;
   logic signed [9:0] qe;

   assign q  = quo_ff[DIV_STAGES-1];
   assign qe = exp_ff[DIV_STAGES-1];

   // Normalize: the quotient lies in [2^22, 2^24)
   always_ff @(posedge clock) begin
      if (en) begin
         if (q[23]) begin
            res_ff <= make_res(sg_ff[DIV_STAGES-1], qe, q[22:0]);
         end else begin
            res_ff <= make_res(sg_ff[DIV_STAGES-1], qe - 10'sd1, {q[21:0], 1'b0});
         end
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== rtl/fp32_truncating_alu_top.sv =====
// ----------------------------------------------------------------------------
// fp32_truncating_alu_top
// Add, subtract, multiply and divide of fp32 operands with truncation.
// ----------------------------------------------------------------------------
// The pipeline depth is set by the divider (8 stages of 3 quotient bits each
// plus a normalize stage); add/subtract and multiply run 3 stages and are
// delayed to the same depth so results leave in order. One request is
// accepted per cycle unless the pipeline holds; the whole pipeline holds
// while a result waits on rsp_tready. Operands are always read as normal
// numbers with an implicit one; no zero, denormal, infinity or NaN handling.
`timescale 1ns / 1ps
`default_nettype none

module fp32_truncating_alu_top
   import fta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // func[1:0], a_sign[2], a_exponent[10:3], a_mantissa[33:11],
   // b_sign[34], b_exponent[42:35], b_mantissa[65:43], zero fill
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // r_sign[0], r_exponent[8:1], r_mantissa[31:9], exp_out_of_range[32],
   // zero fill
   output logic [39:0]      rsp_tdata
);

   logic        en;
   func_type    func;
   logic        a_sign, b_sign, b_sign_eff;
   logic [7:0]  a_exponent, b_exponent;
   logic [22:0] a_mantissa, b_mantissa;

   assign func       = func_type'(req_tdata[1:0]);
   assign a_sign     = req_tdata[2];
   assign a_exponent = req_tdata[10:3];
   assign a_mantissa = req_tdata[33:11];
   assign b_sign     = req_tdata[34];
   assign b_exponent = req_tdata[42:35];
   assign b_mantissa = req_tdata[65:43];
   assign b_sign_eff = b_sign ^ (func == FUNC_SUB);

   logic     vld_ff [DIV_LAT];
   func_type fn_ff  [DIV_LAT];

   // Advance everything unless the last stage holds an untaken result
   assign en         = !vld_ff[DIV_LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < DIV_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fn_ff[0] <= func;
         for (int i = 1; i < DIV_LAT; i++) fn_ff[i] <= fn_ff[i-1];
      end
   end

   res_type add_res, mul_res, div_res;

   fta_addsub u_add (
      .clock(clock), .en(en),
      .a_sign(a_sign), .a_exponent(a_exponent), .a_mantissa(a_mantissa),
      .b_sign(b_sign_eff), .b_exponent(b_exponent), .b_mantissa(b_mantissa),
      .res(add_res)
   );

   fta_mul u_mul (
      .clock(clock), .en(en),
      .a_sign(a_sign), .a_exponent(a_exponent), .a_mantissa(a_mantissa),
      .b_sign(b_sign), .b_exponent(b_exponent), .b_mantissa(b_mantissa),
      .res(mul_res)
   );

   fta_div u_div (
      .clock(clock), .en(en),
      .a_sign(a_sign), .a_exponent(a_exponent), .a_mantissa(a_mantissa),
      .b_sign(b_sign), .b_exponent(b_exponent), .b_mantissa(b_mantissa),
      .res(div_res)
   );

   // Delay the short paths to the divider depth
   res_type add_dly_ff [PAD_LAT];
   res_type mul_dly_ff [PAD_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         add_dly_ff[0] <= add_res;
         mul_dly_ff[0] <= mul_res;
         for (int i = 1; i < PAD_LAT; i++) begin
            add_dly_ff[i] <= add_dly_ff[i-1];
            mul_dly_ff[i] <= mul_dly_ff[i-1];
         end
      end
   end

   res_type out_res;

   // Select the finished result by operation
   always_comb begin
      unique case (fn_ff[DIV_LAT-1]) inside
         FUNC_ADD, FUNC_SUB: out_res = add_dly_ff[PAD_LAT-1];
         FUNC_MUL:           out_res = mul_dly_ff[PAD_LAT-1];
         FUNC_DIV:           out_res = div_res;
         default:            out_res = div_res;
      endcase
   end

   assign rsp_tvalid = vld_ff[DIV_LAT-1];
   assign rsp_tdata  = {7'd0, out_res.oor, out_res.mantissa, out_res.exponent,
                        out_res.sign};

endmodule

`default_nettype wire

// ===== tb/sv/fp32_truncating_alu_top_tb.sv =====
// ----------------------------------------------------------------------------
// fp32_truncating_alu_top_tb
// Self-checking bench for the truncating fp32 add/subtract/multiply/divide
// unit: a directed table of corner requests followed by random requests, with
// random idle bursts on both streams and a built-in predictor for each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fp32_truncating_alu_top_tb;
   import fta_pkg::*;

   localparam int N_RANDOM   = 1280;
   localparam int QUIET_TAIL = 200;
   localparam int WATCHDOG   = 2000;
   localparam int DRAIN_CYC  = 20;

   typedef struct {
      func_type    func;
      logic        a_sign;
      logic [7:0]  a_exp;
      logic [22:0] a_frac;
      logic        b_sign;
      logic [7:0]  b_exp;
      logic [22:0] b_frac;
   } fp_req_t;

   typedef struct packed {
      logic        sign;
      logic [7:0]  exp;
      logic [22:0] frac;
      logic        oor;
   } fp_res_t;

   typedef struct {
      fp_req_t req;
      bit      typed;   // expected result written in the table
      fp_res_t res;
   } vec_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   fp_res_t result_q[$];
   int      err_count  = 0;
   int      idle_cycles = 0;
   int      rsp_hold = 0;
   bit      quiet = 1'b0;
   bit      stim_done = 1'b0;

   fp32_truncating_alu_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Pack a result from an unbounded exponent
   function automatic fp_res_t wrap_res(logic s, int e, logic [23:0] m);
      fp_res_t r;
      r.sign = s;
      r.exp  = e[7:0];
      r.frac = m[22:0];
      r.oor  = (e < 0) || (e > 255);
      return r;
   endfunction

   // Predict the truncated fp32 result of one request
   function automatic fp_res_t fp_compute(fp_req_t q);
      longint ma, mb, sum, mag, prod, num, quo;
      int e, d;
      logic sb, s;
      fp_res_t r;
      ma = {1'b1, q.a_frac};
      mb = {1'b1, q.b_frac};
      case (q.func)
         FUNC_ADD, FUNC_SUB: begin
            sb = q.b_sign ^ (q.func == FUNC_SUB);
            if (q.a_exp > q.b_exp) begin
               d = q.a_exp - q.b_exp;
               mb = (d >= 24) ? 0 : (mb >> d);
               e = q.a_exp;
            end else begin
               d = q.b_exp - q.a_exp;
               ma = (d >= 24) ? 0 : (ma >> d);
               e = q.b_exp;
            end
            sum = (q.a_sign ? -ma : ma) + (sb ? -mb : mb);
            if (sum == 0) begin
               r = wrap_res(1'b0, 0, 24'd0);
            end else begin
               s = sum < 0;
               mag = s ? -sum : sum;
               while (mag >= (64'd1 << 24)) begin mag >>= 1; e++; end
               while (mag < (64'd1 << 23)) begin mag <<= 1; e--; end
               r = wrap_res(s, e, mag[23:0]);
            end
         end
         FUNC_MUL: begin
            prod = ma * mb;
            e = int'(q.a_exp) + int'(q.b_exp) - EXP_BIAS;
            if (prod[47]) begin prod >>= 24; e++; end
            else prod >>= 23;
            r = wrap_res(q.a_sign ^ q.b_sign, e, prod[23:0]);
         end
         default: begin
            num = ma << 23;
            quo = num / mb;
            e = int'(q.a_exp) - int'(q.b_exp) + EXP_BIAS;
            if (quo >= (64'd1 << 24)) begin quo >>= 1; e++; end
            else while (quo < (64'd1 << 23)) begin quo <<= 1; e--; end
            r = wrap_res(q.a_sign ^ q.b_sign, e, quo[23:0]);
         end
      endcase
      return r;
   endfunction

   function automatic fp_req_t mk(func_type f, logic as, logic [7:0] ae, logic [22:0] af,
                                  logic bs, logic [7:0] be, logic [22:0] bf);
      fp_req_t q;
      q.func = f; q.a_sign = as; q.a_exp = ae; q.a_frac = af;
      q.b_sign = bs; q.b_exp = be; q.b_frac = bf;
      return q;
   endfunction

   function automatic fp_res_t rs(logic s, logic [7:0] e, logic [22:0] m, logic o);
      fp_res_t r;
      r.sign = s; r.exp = e; r.frac = m; r.oor = o;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // Send one request, at times with a random idle burst in front (none when quiet)
   task automatic send_req(fp_req_t q);
      fp_res_t r;
      if (!quiet && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tdata  <= {6'd0, q.b_frac, q.b_exp, q.b_sign, q.a_frac, q.a_exp, q.a_sign,
                     q.func};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = fp_compute(q);
      result_q.push_back(r);
      @(negedge clock);
   endtask

   // Random request: half with close exponents so add cancellation is reached
   function automatic fp_req_t rand_req();
      fp_req_t q;
      q = mk(func_type'($urandom_range(3)), $urandom_range(1), $urandom_range(255),
             $urandom, $urandom_range(1), $urandom_range(255), $urandom);
      case ($urandom_range(5))
         0: q.b_exp = q.a_exp + $urandom_range(2);
         1: begin q.b_exp = q.a_exp; q.b_frac = q.a_frac ^ (1 << $urandom_range(22)); end
         2: begin q.b_exp = q.a_exp; q.b_frac = q.a_frac; end
         3: q.b_exp = q.a_exp - 8'd23 - $urandom_range(2);
         default: ;
      endcase
      return q;
   endfunction

   // Response side: random stall bursts, none in the quiet tail
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (rsp_tready && $urandom_range(4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      fp_res_t w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            report("unexpected response", rsp_tdata[31:0], 32'd0);
         end else begin
            w = result_q.pop_front();
            if (rsp_tdata[0] !== w.sign) report("r_sign", rsp_tdata[0], w.sign);
            if (rsp_tdata[8:1] !== w.exp) report("r_exponent", rsp_tdata[8:1], w.exp);
            if (rsp_tdata[31:9] !== w.frac) report("r_mantissa", rsp_tdata[31:9], w.frac);
            if (rsp_tdata[32] !== w.oor) report("exp_out_of_range", rsp_tdata[32], w.oor);
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      vec_t dir[$];
      fp_req_t q;
      fp_res_t p;
      int n;
      // +-1.0 op +-1.0 for every operation
      dir.push_back('{mk(FUNC_ADD, 0, 127, 0, 0, 127, 0), 1, rs(0, 128, 0, 0)});
      dir.push_back('{mk(FUNC_SUB, 0, 127, 0, 0, 127, 0), 1, rs(0, 0, 0, 0)});
      dir.push_back('{mk(FUNC_MUL, 0, 127, 0, 1, 127, 0), 1, rs(1, 127, 0, 0)});
      dir.push_back('{mk(FUNC_DIV, 1, 127, 0, 1, 127, 0), 1, rs(0, 127, 0, 0)});
      // exact cancellation with add and opposite signs
      dir.push_back('{mk(FUNC_ADD, 1, 200, 23'h7FFFFF, 0, 200, 23'h7FFFFF), 1, rs(0, 0, 0, 0)});
      // large alignment both ways
      dir.push_back('{mk(FUNC_ADD, 0, 255, 23'h123456, 0, 0, 23'h7FFFFF), 0, p});
      dir.push_back('{mk(FUNC_SUB, 0, 0, 0, 1, 24, 0), 0, p});
      dir.push_back('{mk(FUNC_ADD, 0, 100, 0, 0, 123, 0), 0, p});
      // carry out of the sum, deep left normalization
      dir.push_back('{mk(FUNC_ADD, 0, 255, 23'h7FFFFF, 0, 255, 23'h7FFFFF), 0, p});
      dir.push_back('{mk(FUNC_SUB, 0, 0, 23'h000001, 0, 0, 0), 0, p});
      dir.push_back('{mk(FUNC_SUB, 1, 10, 23'h7FFFFF, 1, 10, 23'h7FFFFE), 0, p});
      // multiply: top product bit, exponent underflow and overflow
      dir.push_back('{mk(FUNC_MUL, 0, 255, 23'h7FFFFF, 0, 255, 23'h7FFFFF), 0, p});
      dir.push_back('{mk(FUNC_MUL, 1, 0, 0, 0, 0, 0), 1, rs(1, 8'h81, 0, 1)});
      dir.push_back('{mk(FUNC_MUL, 0, 1, 23'h400000, 0, 0, 23'h400000), 0, p});
      // divide: small quotient, extremes of exponents
      dir.push_back('{mk(FUNC_DIV, 0, 0, 0, 0, 255, 23'h7FFFFF), 0, p});
      dir.push_back('{mk(FUNC_DIV, 0, 255, 23'h7FFFFF, 1, 0, 0), 0, p});
      dir.push_back('{mk(FUNC_DIV, 1, 127, 23'h2AAAAA, 0, 127, 23'h555555), 0, p});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir[i]) begin
         if (dir[i].typed && fp_compute(dir[i].req) != dir[i].res)
            report("table row", i, 0);
         send_req(dir[i].req);
      end

      // random part, pausing once until the pipeline drains
      for (n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) begin
            req_tvalid <= 1'b0;
            while (result_q.size() != 0) @(negedge clock);
         end
         if (n == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
         q = rand_req();
         send_req(q);
      end
      req_tvalid <= 1'b0;

      // drain
      n = 0;
      while (result_q.size() != 0 && n < WATCHDOG) begin
         @(negedge clock);
         n++;
      end
      repeat (DRAIN_CYC) @(negedge clock);
      if (err_count == 0 && result_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/fta_pkg.sv
rtl/fta_addsub.sv
rtl/fta_mul.sv
rtl/fta_div.sv
rtl/fp32_truncating_alu_top.sv
tb/sv/fp32_truncating_alu_top_tb.sv
